// ===== hdl/frwr_pkg.sv =====
`default_nettype none

package frwr_pkg;

    localparam int STORE_BYTES_DEF   = 32;
    localparam int MAX_REGISTERS_DEF = 8;

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_FRAMED = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_SIZES  = 2'd2;

    localparam logic        FRAMED_RST = 1'b1;
    localparam logic [3:0]  COUNT_RST  = 4'd8;
    localparam logic [23:0] SIZES_RST  = 24'h924924;

    // input operations
    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // result status codes
    localparam logic [2:0] RES_CONSUMED  = 3'd0;
    localparam logic [2:0] RES_WRITTEN   = 3'd1;
    localparam logic [2:0] RES_FRAME_END = 3'd2;
    localparam logic [2:0] RES_BAD_ID    = 3'd3;
    localparam logic [2:0] RES_READ      = 3'd4;
    localparam logic [2:0] RES_TX        = 3'd5;

    localparam logic [7:0] FRAME_OPEN  = 8'hFF;
    localparam logic [7:0] FRAME_CLOSE = 8'hFE;

    typedef struct packed {
        logic        framed;
        logic [3:0]  count;
        logic [23:0] sizes;
    } cfg_t;

    typedef struct packed {
        logic rx_step;
        logic load_plain;
        logic read_start;
        logic read_issue;
        logic read_emit;
        logic dump_start;
        logic dump_open;
        logic dump_id;
        logic dump_fetch;
        logic dump_data;
        logic dump_close;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic byte_last;
        logic reg_last;
    } stat_t;

    // size field of register r, 0 taken as 1 and 5..7 as 4
    function automatic logic [2:0] reg_size(input logic [23:0] sizes, input logic [2:0] r);
        logic [2:0] s;
        s = 3'(sizes >> (5'(r) * 5'd3));
        if (s == 3'd0)
        begin
            s = 3'd1;
        end
        else if (s > 3'd4)
        begin
            s = 3'd4;
        end
        return s;
    endfunction

    function automatic logic [3:0] reg_count(input logic [3:0] c, input logic [3:0] max_r);
        logic [3:0] v;
        v = c;
        if (v == 4'd0)
        begin
            v = 4'd1;
        end
        else if (v > max_r)
        begin
            v = max_r;
        end
        return v;
    endfunction

    // byte offset of register r: sum of the sizes below it
    function automatic logic [5:0] reg_offset(input logic [23:0] sizes, input logic [2:0] r);
        logic [5:0] sum;
        sum = 6'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < r)
            begin
                sum = sum + 6'(reg_size(sizes, 3'(i)));
            end
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/frwr_if.sv =====
`default_nettype none

interface frwr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [2:0] reg_num;

    modport source (output valid, output op, output rx_byte, output reg_num, input ready);
    modport sink   (input valid, input op, input rx_byte, input reg_num, output ready);
endinterface

interface frwr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    logic [7:0]  updated_mask;
    logic        last;

    modport source (output valid, output status, output tx_byte, output read_value,
                    output updated_mask, output last, input ready);
    modport sink   (input valid, input status, input tx_byte, input read_value,
                    input updated_mask, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/frwr_cfg_regs.sv =====
`default_nettype none

module frwr_cfg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [frwr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [frwr_pkg::CFG_DW-1:0] pwdata,
    output logic      [frwr_pkg::CFG_DW-1:0] prdata,
    output logic                            pready,
    output frwr_pkg::cfg_t                  cfg
);

    logic        framed_reg;
    logic [3:0]  count_reg;
    logic [23:0] sizes_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framed_reg <= frwr_pkg::FRAMED_RST;
            count_reg  <= frwr_pkg::COUNT_RST;
            sizes_reg  <= frwr_pkg::SIZES_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == frwr_pkg::REG_FRAMED)
            begin
                framed_reg <= pwdata[0];
            end
            if (reg_idx == frwr_pkg::REG_COUNT)
            begin
                count_reg <= pwdata[3:0];
            end
            if (reg_idx == frwr_pkg::REG_SIZES)
            begin
                sizes_reg <= pwdata[23:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            frwr_pkg::REG_FRAMED: prdata = {31'd0, framed_reg};
            frwr_pkg::REG_COUNT:  prdata = {28'd0, count_reg};
            frwr_pkg::REG_SIZES:  prdata = {8'd0, sizes_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.framed = framed_reg;
    assign cfg.count  = count_reg;
    assign cfg.sizes  = sizes_reg;

endmodule

`default_nettype wire

// ===== hdl/frwr_ctrl.sv =====
`default_nettype none

module frwr_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [1:0]      in_op,
    output logic                 in_ready,
    input  wire frwr_pkg::stat_t stat,
    output frwr_pkg::cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_READ_ISSUE = 8'b0000_0010,
        ST_READ_WAIT  = 8'b0000_0100,
        ST_D_OPEN     = 8'b0000_1000,
        ST_D_ID       = 8'b0001_0000,
        ST_D_FETCH    = 8'b0010_0000,
        ST_D_DATA     = 8'b0100_0000,
        ST_D_CLOSE    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    unique case (in_op)
                        frwr_pkg::OP_RX:   cmd.rx_step = 1'b1;
                        frwr_pkg::OP_READ:
                        begin
                            cmd.read_start = 1'b1;
                            state_next     = ST_READ_ISSUE;
                        end
                        frwr_pkg::OP_DUMP:
                        begin
                            cmd.dump_start = 1'b1;
                            state_next     = ST_D_OPEN;
                        end
                        frwr_pkg::OP_NONE: cmd.load_plain = 1'b1;
                    endcase
                end
            end
            ST_READ_ISSUE:
            begin
                cmd.read_issue = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.read_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_D_OPEN:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_open = 1'b1;
                    state_next    = ST_D_ID;
                end
            end
            ST_D_ID:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_id = 1'b1;
                    state_next  = ST_D_FETCH;
                end
            end
            ST_D_FETCH:
            begin
                cmd.dump_fetch = 1'b1;
                state_next     = ST_D_DATA;
            end
            ST_D_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_data = 1'b1;
                    if (!stat.byte_last)
                    begin
                        state_next = ST_D_FETCH;
                    end
                    else if (stat.reg_last)
                    begin
                        state_next = ST_D_CLOSE;
                    end
                    else
                    begin
                        state_next = ST_D_ID;
                    end
                end
            end
            ST_D_CLOSE:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_close = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/frwr_datapath.sv =====
`default_nettype none

module frwr_datapath
#(
    parameter int STORE_BYTES   = frwr_pkg::STORE_BYTES_DEF,
    parameter int MAX_REGISTERS = frwr_pkg::MAX_REGISTERS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire frwr_pkg::cfg_t  cfg,
    input  wire frwr_pkg::cmd_t  cmd,
    output frwr_pkg::stat_t      stat,
    input  wire logic [7:0]      in_rx_byte,
    input  wire logic [2:0]      in_reg_num,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output logic [2:0]           out_status,
    output logic [7:0]           out_tx_byte,
    output logic [31:0]          out_read_value,
    output logic [7:0]           out_updated_mask,
    output logic                 out_last
);

    localparam int         AW        = $clog2(STORE_BYTES);
    localparam logic [6:0] STORE_LIM = 7'(STORE_BYTES);
    localparam logic [3:0] MAX_R     = 4'(MAX_REGISTERS);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ID      = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [2:0] cur_reg, cur_next;
    logic [2:0] left_reg, left_next;
    logic [5:0] boff_reg, boff_next;
    logic [7:0] upd_reg, upd_next;

    // byte store, one valid bit per entry so unwritten bytes read zero
    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [7:0]             rd_raw_reg;
    logic                   rd_ok_reg;
    logic [7:0]             rd_byte;
    logic                   wr_en;
    logic                   rd_en;

    // read / dump sequencer
    logic [5:0]  addr_reg, addr_next;
    logic [1:0]  j_reg, j_next;
    logic [2:0]  n_reg, n_next;
    logic [2:0]  r_reg, r_next;
    logic        inrange_reg, inrange_next;
    logic [31:0] acc_reg, acc_next;
    logic        pend_reg, pend_next;
    logic [1:0]  lane_reg, lane_next;
    logic [31:0] rd_shift;
    logic [31:0] acc_view;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [7:0]  out_tx_reg, out_tx_next;
    logic [31:0] out_rv_reg, out_rv_next;
    logic [7:0]  out_mask_reg, out_mask_next;
    logic        out_last_reg, out_last_next;

    logic [3:0]  cnt;
    logic        id_ok;
    logic        do_start;
    logic [2:0]  left_dec;
    logic [2:0]  rx_status;
    logic        load;

    assign cnt      = frwr_pkg::reg_count(cfg.count, MAX_R);
    assign id_ok    = {4'd0, cnt} > in_rx_byte;
    assign left_dec = left_reg - 3'd1;
    assign rd_byte  = rd_ok_reg ? rd_raw_reg : 8'd0;
    assign rd_shift = {24'd0, rd_byte} << {lane_reg, 3'b000};
    assign acc_view = acc_reg | (pend_reg ? rd_shift : 32'd0);

    // receive parser
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        boff_next  = boff_reg;
        upd_next   = upd_reg;
        rx_status  = frwr_pkg::RES_CONSUMED;
        wr_en      = 1'b0;
        do_start   = 1'b0;
        if (cmd.rx_step)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    wr_en     = {1'b0, boff_reg} < STORE_LIM;
                    boff_next = boff_reg + 6'd1;
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        upd_next   = upd_reg | (8'd1 << cur_reg);
                        phase_next = cfg.framed ? PH_ID : PH_IDLE;
                        rx_status  = frwr_pkg::RES_WRITTEN;
                    end
                end
                PH_ID:
                begin
                    if (!cfg.framed)
                    begin
                        do_start = 1'b1;
                    end
                    else if (in_rx_byte == frwr_pkg::FRAME_CLOSE)
                    begin
                        phase_next = PH_IDLE;
                        rx_status  = frwr_pkg::RES_FRAME_END;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                PH_IDLE:
                begin
                    if (!cfg.framed)
                    begin
                        do_start = 1'b1;
                    end
                    else if (in_rx_byte == frwr_pkg::FRAME_OPEN)
                    begin
                        upd_next   = 8'd0;
                        phase_next = PH_ID;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
            if (do_start)
            begin
                if (id_ok)
                begin
                    cur_next   = in_rx_byte[2:0];
                    left_next  = frwr_pkg::reg_size(cfg.sizes, in_rx_byte[2:0]);
                    boff_next  = frwr_pkg::reg_offset(cfg.sizes, in_rx_byte[2:0]);
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    rx_status  = frwr_pkg::RES_BAD_ID;
                end
            end
        end
    end

    // read and dump sequencing
    always_comb
    begin
        addr_next    = addr_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        inrange_next = inrange_reg;
        acc_next     = acc_reg;
        pend_next    = 1'b0;
        lane_next    = lane_reg;
        rd_en        = 1'b0;
        if (pend_reg)
        begin
            acc_next = acc_view;
        end
        if (cmd.read_start)
        begin
            addr_next    = frwr_pkg::reg_offset(cfg.sizes, in_reg_num);
            n_next       = frwr_pkg::reg_size(cfg.sizes, in_reg_num);
            j_next       = 2'd0;
            inrange_next = {1'b0, in_reg_num} < cnt;
            acc_next     = 32'd0;
        end
        if (cmd.read_issue)
        begin
            rd_en     = 1'b1;
            addr_next = addr_reg + 6'd1;
            j_next    = j_reg + 2'd1;
            pend_next = 1'b1;
            lane_next = j_reg;
        end
        if (cmd.dump_start)
        begin
            addr_next = 6'd0;
            j_next    = 2'd0;
            r_next    = 3'd0;
            n_next    = frwr_pkg::reg_size(cfg.sizes, 3'd0);
        end
        if (cmd.dump_fetch)
        begin
            rd_en = 1'b1;
        end
        if (cmd.dump_data)
        begin
            addr_next = addr_reg + 6'd1;
            if (stat.byte_last)
            begin
                j_next = 2'd0;
                r_next = r_reg + 3'd1;
                n_next = frwr_pkg::reg_size(cfg.sizes, r_reg + 3'd1);
            end
            else
            begin
                j_next = j_reg + 2'd1;
            end
        end
    end

    assign stat.byte_last = j_reg == 2'(n_reg - 3'd1);
    assign stat.reg_last  = {1'b0, r_reg} == (cnt - 4'd1);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // result register
    assign load = cmd.rx_step || cmd.load_plain || cmd.read_emit || cmd.dump_open
                  || cmd.dump_id || cmd.dump_data || cmd.dump_close;

    always_comb
    begin
        out_status_next = out_status_reg;
        out_tx_next     = out_tx_reg;
        out_rv_next     = out_rv_reg;
        out_mask_next   = out_mask_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_mask_next   = upd_next;
            out_tx_next     = 8'd0;
            out_rv_next     = 32'd0;
            out_last_next   = cmd.rx_step || cmd.load_plain || cmd.read_emit || cmd.dump_close;
            out_status_next = frwr_pkg::RES_TX;
            if (cmd.rx_step)
            begin
                out_status_next = rx_status;
            end
            if (cmd.load_plain)
            begin
                out_status_next = frwr_pkg::RES_CONSUMED;
            end
            if (cmd.read_emit)
            begin
                out_status_next = frwr_pkg::RES_READ;
                out_rv_next     = inrange_reg ? acc_view : 32'd0;
            end
            if (cmd.dump_open)
            begin
                out_tx_next = frwr_pkg::FRAME_OPEN;
            end
            if (cmd.dump_id)
            begin
                out_tx_next = {5'd0, r_reg};
            end
            if (cmd.dump_data)
            begin
                out_tx_next = rd_byte;
            end
            if (cmd.dump_close)
            begin
                out_tx_next = frwr_pkg::FRAME_CLOSE;
            end
        end
    end

    // store array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[boff_reg[AW-1:0]] <= in_rx_byte;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            cur_reg       <= 3'd0;
            left_reg      <= 3'd0;
            boff_reg      <= 6'd0;
            upd_reg       <= 8'd0;
            addr_reg      <= 6'd0;
            j_reg         <= 2'd0;
            n_reg         <= 3'd1;
            r_reg         <= 3'd0;
            inrange_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            lane_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[boff_reg[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[addr_reg[AW-1:0]] && ({1'b0, addr_reg} < STORE_LIM);
            end
            phase_reg     <= phase_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            boff_reg      <= boff_next;
            upd_reg       <= upd_next;
            addr_reg      <= addr_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            r_reg         <= r_next;
            inrange_reg   <= inrange_next;
            pend_reg      <= pend_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        out_status_reg <= out_status_next;
        out_tx_reg     <= out_tx_next;
        out_rv_reg     <= out_rv_next;
        out_mask_reg   <= out_mask_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_tx_byte      = out_tx_reg;
    assign out_read_value   = out_rv_reg;
    assign out_updated_mask = out_mask_reg;
    assign out_last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while a result is still waiting");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != 3'd0))
        else $error("payload phase with no bytes left");

    a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rx_step && phase_reg == PH_IDLE && cfg.framed
         && in_rx_byte == frwr_pkg::FRAME_OPEN)
        |=> (upd_reg == 8'd0 && phase_reg == PH_ID))
        else $error("frame open did not clear the updated mask");
`endif

endmodule

`default_nettype wire

// ===== hdl/framed_register_write_receiver_core.sv =====
// Framed register write receiver.
// in_ch carries items {op, rx_byte, reg_num}; out_ch returns result items
// {status, tx_byte, read_value, updated_mask, last}; last marks the final
// result of each input item. Both channels move an item when valid and ready
// are high at a rising edge. The APB port holds framed_mode (0x0),
// register_count (0x4) and register_sizes (0x8); pready is tied high.
// Timing, with the receiver always ready:
//   received byte / unused op: one result, valid the cycle after acceptance;
//     one item per cycle, set by the single result register.
//   read: one store read per cycle for each of the n register bytes, then
//     one result with the value. dump: open byte, each register's id and
//     data bytes, close byte; each data byte is fetched, then emitted.
// in_ch.ready is high only when no read or dump is running and the result
// register is empty or being taken; a stalled receiver holds the pending
// result and the block accepts nothing further until it is taken.
// Reset clears the store (reads return zero until written), the parser and
// updated mask, and loads the register defaults (framed, 8 registers of 4).
`default_nettype none

module framed_register_write_receiver_core
#(
    parameter int STORE_BYTES   = frwr_pkg::STORE_BYTES_DEF,
    parameter int MAX_REGISTERS = frwr_pkg::MAX_REGISTERS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    frwr_in_if.sink                          in_ch,
    frwr_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [frwr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [frwr_pkg::CFG_DW-1:0] pwdata,
    output logic      [frwr_pkg::CFG_DW-1:0] prdata,
    output logic                             pready
);

    frwr_pkg::cfg_t  cfg;
    frwr_pkg::cmd_t  cmd;
    frwr_pkg::stat_t stat;

    // configuration registers
    frwr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // op sequencer: accepts items, steps reads and dumps
    frwr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parser, byte store and result register
    frwr_datapath #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .in_rx_byte       (in_ch.rx_byte),
        .in_reg_num       (in_ch.reg_num),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_status       (out_ch.status),
        .out_tx_byte      (out_ch.tx_byte),
        .out_read_value   (out_ch.read_value),
        .out_updated_mask (out_ch.updated_mask),
        .out_last         (out_ch.last)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Bench for the framed register write receiver.
// Items go in on in_if in bursts with random gaps; results are taken from out_if
// under a stall pattern picked anew whenever tick[5:0] is zero. A shadow copy of the
// register file and the byte parser works out the results each accepted item
// owes. Every result that comes out is checked against the oldest one owed.
module testbench;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [2:0] reg_num;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  tx_byte;
        logic [31:0] read_value;
        logic [7:0]  mask;
        logic        last;
    } result_t;

    // row of the directed table; pinned rows carry a hand-written status and value
    typedef struct packed {
        item_t       item;
        logic        pinned;
        logic [2:0]  status;
        logic [31:0] value;
    } row_t;

    typedef enum logic [1:0] {PH_IDLE, PH_ID, PH_PAYLOAD, PH_HOLD} phase_t;

    localparam int DIR_ROWS   = 25;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 16;
    localparam int SHADOW_LEN = frwr_pkg::STORE_BYTES_DEF;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [frwr_pkg::CFG_AW-1:0] paddr;
    logic [frwr_pkg::CFG_DW-1:0] pwdata;
    logic [frwr_pkg::CFG_DW-1:0] prdata;
    logic pready;

    frwr_in_if  in_if ();
    frwr_out_if out_if ();

    framed_register_write_receiver_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow configuration, updated as each register write lands
    logic        sh_framed;
    logic [3:0]  sh_count;
    logic [23:0] sh_sizes;

    // shadow store and parser
    logic [7:0] sh_store [SHADOW_LEN];
    logic [7:0] sh_mask;
    phase_t     sh_phase;
    logic [2:0] sh_reg;
    logic [2:0] sh_left;
    logic [5:0] sh_offset;

    result_t owed [$];      // results the block still has to hand over
    item_t   stim_q [$];    // random items staged for the current phase
    row_t    dir_rows [DIR_ROWS];
    int      faults;
    int      burst_left;

    // stall pattern of the result side
    logic [1:0]  stall_mode;
    logic [15:0] tick;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop; far beyond the slowest legal run (every item a full dump,
    // receiver mostly stalled)
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // shadow of the block
    // ---------------------------------------------------------------

    // byte size of register r: a field of 0 counts as 1, 5..7 as 4
    function automatic logic [2:0] size_of(input logic [2:0] r);
        logic [2:0] s;
        s = sh_sizes[3*int'(r) +: 3];
        if (s == 3'd0)
        begin
            s = 3'd1;
        end
        if (s > 3'd4)
        begin
            s = 3'd4;
        end
        return s;
    endfunction

    function automatic logic [3:0] count_of();
        logic [3:0] c;
        c = sh_count;
        if (c == 4'd0)
        begin
            c = 4'd1;
        end
        if (c > 4'd8)
        begin
            c = 4'd8;
        end
        return c;
    endfunction

    // registers are packed back to back from byte 0
    function automatic logic [5:0] offset_of(input logic [2:0] r);
        logic [5:0] sum;
        sum = 6'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < int'(r))
            begin
                sum = sum + 6'(size_of(3'(i)));
            end
        end
        return sum;
    endfunction

    function automatic logic [7:0] byte_at(input logic [5:0] addr);
        return (int'(addr) < SHADOW_LEN) ? sh_store[addr[4:0]] : 8'd0;
    endfunction

    function automatic void owe(input logic [2:0] st, input logic [7:0] tx,
                                input logic [31:0] rv);
        result_t r;
        r.status     = st;
        r.tx_byte    = tx;
        r.read_value = rv;
        r.mask       = sh_mask;
        r.last       = 1'b0;
        owed.push_back(r);
    endfunction

    // an id byte: unknown ids drop the frame, known ones latch offset and length
    function automatic logic [2:0] open_register(input logic [7:0] id);
        if (id >= 8'(count_of()))
        begin
            sh_phase = PH_IDLE;
            return frwr_pkg::RES_BAD_ID;
        end
        sh_reg    = id[2:0];
        sh_left   = size_of(id[2:0]);
        sh_offset = offset_of(id[2:0]);
        sh_phase  = PH_PAYLOAD;
        return frwr_pkg::RES_CONSUMED;
    endfunction

    function automatic logic [2:0] take_byte(input logic [7:0] b);
        if (sh_phase == PH_PAYLOAD)
        begin
            // payload runs to completion at its latched offset, whatever the mode now
            if (int'(sh_offset) < SHADOW_LEN)
            begin
                sh_store[sh_offset[4:0]] = b;
            end
            sh_offset = sh_offset + 6'd1;
            sh_left   = sh_left - 3'd1;
            if (sh_left != 3'd0)
            begin
                return frwr_pkg::RES_CONSUMED;
            end
            sh_mask  = sh_mask | (8'd1 << sh_reg);
            sh_phase = sh_framed ? PH_ID : PH_IDLE;
            return frwr_pkg::RES_WRITTEN;
        end
        if (!sh_framed)
        begin
            return open_register(b);
        end
        if (sh_phase == PH_ID)
        begin
            if (b == frwr_pkg::FRAME_CLOSE)
            begin
                sh_phase = PH_IDLE;
                return frwr_pkg::RES_FRAME_END;
            end
            return open_register(b);
        end
        // idle in framed mode: only the opening byte does anything
        if (b == frwr_pkg::FRAME_OPEN)
        begin
            sh_mask  = 8'd0;
            sh_phase = PH_ID;
        end
        return frwr_pkg::RES_CONSUMED;
    endfunction

    // advance the shadow by one accepted item and queue what it owes
    function automatic void shadow_step(input item_t it);
        logic [31:0] v;
        logic [5:0]  addr;
        logic [2:0]  n;
        logic [2:0]  st;
        v    = 32'd0;
        addr = 6'd0;
        case (it.op)
            frwr_pkg::OP_RX:
            begin
                st = take_byte(it.rx_byte);
                owe(st, 8'd0, 32'd0);
            end
            frwr_pkg::OP_READ:
            begin
                // unused registers read as zero
                if (4'(it.reg_num) < count_of())
                begin
                    n = size_of(it.reg_num);
                    for (int i = 0; i < int'(n); i++)
                    begin
                        v[8*i +: 8] = byte_at(offset_of(it.reg_num) + 6'(i));
                    end
                end
                owe(frwr_pkg::RES_READ, 8'd0, v);
            end
            frwr_pkg::OP_DUMP:
            begin
                owe(frwr_pkg::RES_TX, frwr_pkg::FRAME_OPEN, 32'd0);
                for (int r = 0; r < int'(count_of()); r++)
                begin
                    n = size_of(3'(r));
                    owe(frwr_pkg::RES_TX, 8'(r), 32'd0);
                    for (int j = 0; j < int'(n); j++)
                    begin
                        owe(frwr_pkg::RES_TX, byte_at(addr + 6'(j)), 32'd0);
                    end
                    addr = addr + 6'(n);
                end
                owe(frwr_pkg::RES_TX, frwr_pkg::FRAME_CLOSE, 32'd0);
            end
            default:
            begin
                owe(frwr_pkg::RES_CONSUMED, 8'd0, 32'd0);
            end
        endcase
        owed[$].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // APB write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never lower and raise psel in one step
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= frwr_pkg::CFG_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            frwr_pkg::REG_FRAMED: sh_framed = val[0];
            frwr_pkg::REG_COUNT:  sh_count  = val[3:0];
            frwr_pkg::REG_SIZES:  sh_sizes  = val[23:0];
            default:              ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic framed, input logic [3:0] count,
                              input logic [23:0] sizes);
        cfg_write(frwr_pkg::REG_FRAMED, 32'(framed));
        cfg_write(frwr_pkg::REG_COUNT, 32'(count));
        cfg_write(frwr_pkg::REG_SIZES, 32'(sizes));
    endtask

    // offer one item; bursts of random length, each followed by a random gap
    task automatic send_item(input item_t it);
        if (burst_left == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
            begin
                @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= it.op;
        in_if.rx_byte <= it.rx_byte;
        in_if.reg_num <= it.reg_num;
        @(posedge clk);
        while (!in_if.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        shadow_step(it);
    endtask

    // block is idle once every owed result is out (every item owes at least one)
    task automatic drain();
        in_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed.size() != 0);
    endtask

    function automatic void stage(input logic [1:0] op, input logic [7:0] b,
                                  input logic [2:0] rn);
        item_t it;
        it.op      = op;
        it.rx_byte = b;
        it.reg_num = rn;
        stim_q.push_back(it);
    endfunction

    function automatic void stage_byte(input logic [7:0] b);
        stage(frwr_pkg::OP_RX, b, 3'($urandom_range(0, 7)));
    endfunction

    // mostly well-formed writes with random content, some reads and dumps,
    // and a share of noise and broken frames
    function automatic void build_phase(input int n);
        int pick;
        int regs;
        logic [7:0] id;
        logic ok;
        while (stim_q.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                ok = 1'b1;
                if (sh_framed)
                begin
                    stage_byte(frwr_pkg::FRAME_OPEN);
                end
                regs = $urandom_range(1, 3);
                for (int k = 0; k < regs && ok; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        id = 8'($urandom_range(int'(count_of()), 255));
                        ok = 1'b0;
                    end
                    else
                    begin
                        id = 8'($urandom_range(0, int'(count_of()) - 1));
                    end
                    stage_byte(id);
                    if (ok)
                    begin
                        for (int j = 0; j < int'(size_of(id[2:0])); j++)
                        begin
                            stage_byte(8'($urandom_range(0, 255)));
                        end
                    end
                end
                // now and then the close is left out
                if (sh_framed && ok && $urandom_range(0, 9) != 0)
                begin
                    stage_byte(frwr_pkg::FRAME_CLOSE);
                end
            end
            else if (pick < 76)
            begin
                stage(frwr_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)));
            end
            else if (pick < 80)
            begin
                stage(frwr_pkg::OP_DUMP, 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)));
            end
            else if (pick < 85)
            begin
                stage(frwr_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)));
            end
            else
            begin
                stage(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)));
            end
        end
    endfunction

    function automatic row_t row(input logic [1:0] op, input logic [7:0] b,
                                 input logic [2:0] rn, input logic pinned,
                                 input logic [2:0] st, input logic [31:0] v);
        row_t r;
        r.item.op      = op;
        r.item.rx_byte = b;
        r.item.reg_num = rn;
        r.pinned       = pinned;
        r.status       = st;
        r.value        = v;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result side: stall pattern and checker
    // ---------------------------------------------------------------

    // whenever tick[5:0] is zero pick a new way of stalling: always ready,
    // mostly ready, alternating ready and stalled, or mostly stalled
    always @(posedge clk)
    begin
        tick <= tick + 16'd1;
        if (tick[5:0] == 6'd0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0:    out_if.ready <= 1'b1;
            2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_if.ready <= tick[0];
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got.status     = out_if.status;
            got.tx_byte    = out_if.tx_byte;
            got.read_value = out_if.read_value;
            got.mask       = out_if.updated_mask;
            got.last       = out_if.last;
            if (owed.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display({"unexpected result: status %0d tx %02h value %08h",
                              " mask %02h last %0d"},
                             got.status, got.tx_byte, got.read_value, got.mask, got.last);
                end
            end
            else
            begin
                want = owed.pop_front();
                if (got !== want)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $display({"mismatch at %0t: want status %0d tx %02h",
                                  " value %08h mask %02h last %0d"},
                                 $realtime, want.status, want.tx_byte, want.read_value,
                                 want.mask, want.last);
                        $display({"                got  status %0d tx %02h",
                                  " value %08h mask %02h last %0d"},
                                 got.status, got.tx_byte, got.read_value, got.mask,
                                 got.last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [3:0]  ph_count [PHASES];
        logic        ph_framed [PHASES];
        logic [23:0] ph_sizes [PHASES];

        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid   = 1'b0;
        in_if.op      = frwr_pkg::OP_RX;
        in_if.rx_byte = 8'd0;
        in_if.reg_num = 3'd0;
        out_if.ready  = 1'b1;
        stall_mode   = 2'd0;
        tick         = 16'd0;
        faults       = 0;
        burst_left   = 0;

        // shadow starts from the reset state: framed, eight registers of four bytes
        sh_framed = frwr_pkg::FRAMED_RST;
        sh_count  = frwr_pkg::COUNT_RST;
        sh_sizes  = frwr_pkg::SIZES_RST;
        foreach (sh_store[i])
        begin
            sh_store[i] = 8'd0;
        end
        sh_mask   = 8'd0;
        sh_phase  = PH_IDLE;
        sh_reg    = 3'd0;
        sh_left   = 3'd0;
        sh_offset = 6'd0;

        // directed table, run on the reset configuration
        dir_rows = '{
            // store clear
            row(frwr_pkg::OP_READ, 8'h00, 3'd0, 1'b1, frwr_pkg::RES_READ, 32'h0),
            row(frwr_pkg::OP_READ, 8'hFF, 3'd7, 1'b1, frwr_pkg::RES_READ, 32'h0),
            // byte outside a frame
            row(frwr_pkg::OP_RX, 8'h00, 3'd7, 1'b1, frwr_pkg::RES_CONSUMED, 32'h0),
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_OPEN, 3'd0, 1'b0, 3'd0, 32'h0),
            // id 0
            row(frwr_pkg::OP_RX, 8'h00, 3'd1, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h11, 3'd2, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h22, 3'd3, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h33, 3'd4, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h44, 3'd5, 1'b1, frwr_pkg::RES_WRITTEN, 32'h0),
            // top register
            row(frwr_pkg::OP_RX, 8'h07, 3'd6, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h00, 3'd0, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'hFF, 3'd7, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h80, 3'd0, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, 8'h7F, 3'd7, 1'b1, frwr_pkg::RES_WRITTEN, 32'h0),
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_CLOSE, 3'd0, 1'b1,
                frwr_pkg::RES_FRAME_END, 32'h0),
            row(frwr_pkg::OP_READ, 8'h00, 3'd0, 1'b1, frwr_pkg::RES_READ, 32'h4433_2211),
            row(frwr_pkg::OP_READ, 8'h00, 3'd7, 1'b1, frwr_pkg::RES_READ, 32'h7F80_FF00),
            // longest result run
            row(frwr_pkg::OP_DUMP, 8'hFF, 3'd7, 1'b0, 3'd0, 32'h0),
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_OPEN, 3'd0, 1'b0, 3'd0, 32'h0),
            // id past the count
            row(frwr_pkg::OP_RX, 8'h08, 3'd0, 1'b1, frwr_pkg::RES_BAD_ID, 32'h0),
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_OPEN, 3'd0, 1'b0, 3'd0, 32'h0),
            // open byte as id
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_OPEN, 3'd0, 1'b1,
                frwr_pkg::RES_BAD_ID, 32'h0),
            // unused op
            row(frwr_pkg::OP_NONE, 8'hAA, 3'd5, 1'b1, frwr_pkg::RES_CONSUMED, 32'h0),
            row(frwr_pkg::OP_READ, 8'h55, 3'd3, 1'b0, 3'd0, 32'h0),
            // close while idle
            row(frwr_pkg::OP_RX, frwr_pkg::FRAME_CLOSE, 3'd2, 1'b1,
                frwr_pkg::RES_CONSUMED, 32'h0)
        };

        // settings for the random phases: defaults, both modes, counts 0, 1
        // and above the maximum, all-zero and all-ones size fields
        ph_framed = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        ph_count  = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd8, 4'd1, 4'd6, 4'd9};
        ph_sizes  = '{frwr_pkg::SIZES_RST, 24'h0, 24'h000000, 24'hFFFFFF,
                      24'h0, 24'h0, 24'h0, 24'h0};
        foreach (ph_sizes[p])
        begin
            if (p == 1 || p > 3)
            begin
                ph_sizes[p] = 24'($urandom());
            end
        end

        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].item);
            // pinned rows are held to the hand-written outcome
            if (dir_rows[i].pinned)
            begin
                owed[$].status     = dir_rows[i].status;
                owed[$].read_value = dir_rows[i].value;
            end
        end
        drain();

        // random phases; a payload left open at the end of one phase runs on
        // into the next setting
        for (int p = 0; p < PHASES; p++)
        begin
            set_config(ph_framed[p], ph_count[p], ph_sizes[p]);
            build_phase(PHASE_LEN);
            while (stim_q.size() != 0)
            begin
                send_item(stim_q.pop_front());
            end
            drain();
        end

        // let any stray result show up
        repeat (100)
        begin
            @(posedge clk);
        end
        if (faults == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
